>>> src/cobs_deframer_crc16_check_unit_defines.svh
// Assertion macros used by the deframer core RTL.
`ifndef COBS_DEFRAMER_CRC16_CHECK_UNIT_DEFINES_SVH
`define COBS_DEFRAMER_CRC16_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CDC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cdc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define CDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cdc assertion failed");
`else
`define CDC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CDC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> src/cdc_pkg.sv
package cdc_pkg;

    // Default bound on encoded bytes held for one frame
    localparam int MAX_ENCODED_DEF = 512;

    // Frame format constants
    localparam logic [7:0]  DELIM_BYTE  = 8'h00;
    localparam logic [7:0]  FULL_CODE   = 8'hFF;
    localparam int          MIN_DECODED = 6;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    // Result kinds
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_CRC_BAD = 3'd2;
    localparam logic [2:0] KIND_LEN_BAD = 3'd3;
    localparam logic [2:0] KIND_DROPPED = 3'd4;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [8:0]  byte_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_seq;
        logic [15:0] body_length;
    } cdc_result_t;

    // CRC-16/CCITT-FALSE update over one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/cdc_frame_core.sv
`include "cobs_deframer_crc16_check_unit_defines.svh"

module cdc_frame_core
    import cdc_pkg::*;
#(
    parameter int MAX_ENCODED = MAX_ENCODED_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  line_byte,
    output logic        res_valid,
    output cdc_result_t res
);

    localparam int CW = $clog2(MAX_ENCODED + 1);

    logic [CW-1:0] enc_reg,        enc_next;
    logic [CW-1:0] dec_reg,        dec_next;
    logic [7:0]    group_left_reg, group_left_next;
    logic          full_reg,       full_next;
    logic [7:0]    type_reg,       type_next;
    logic [7:0]    seq_reg,        seq_next;
    logic [15:0]   len_reg,        len_next;
    logic [15:0]   crc_reg,        crc_next;
    logic [7:0]    d0_reg,         d0_next;
    logic [7:0]    d1_reg,         d1_next;
    logic [1:0]    fill_reg,       fill_next;

    logic          restart;
    logic          dec_take;
    logic [7:0]    dec_val;
    logic [16:0]   len_sum;
    logic [8:0]    idx_low;

    assign len_sum = {1'b0, len_reg} + 17'(MIN_DECODED);
    assign idx_low = 9'(dec_reg);

    // Decode one transfer and form its result
    always_comb
    begin
        enc_next        = enc_reg;
        dec_next        = dec_reg;
        group_left_next = group_left_reg;
        full_next       = full_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        d0_next         = d0_reg;
        d1_next         = d1_reg;
        fill_next       = fill_reg;
        restart         = 1'b0;
        dec_take        = 1'b0;
        dec_val         = '0;
        res_valid       = 1'b0;
        res             = '0;

        if (take) begin
            if (line_byte == DELIM_BYTE) begin
                // Delimiter: give the verdict unless the frame is empty
                restart = 1'b1;
                if (enc_reg != '0) begin
                    res_valid = 1'b1;
                    if (group_left_reg != '0 || dec_reg < CW'(MIN_DECODED)) begin
                        res.kind = KIND_DROPPED;
                    end
                    else if (len_sum != 17'(dec_reg)) begin
                        res.kind        = KIND_LEN_BAD;
                        res.frame_type  = type_reg;
                        res.body_length = len_reg;
                    end
                    else begin
                        res.kind        = ({d1_reg, d0_reg} == crc_reg) ? KIND_OK
                                                                        : KIND_CRC_BAD;
                        res.frame_type  = type_reg;
                        res.frame_seq   = seq_reg;
                        res.body_length = len_reg;
                    end
                end
            end
            else if (enc_reg >= CW'(MAX_ENCODED)) begin
                // Overflow: drop the byte and restart the frame
                res_valid = 1'b1;
                res.kind  = KIND_DROPPED;
                restart   = 1'b1;
            end
            else begin
                enc_next = enc_reg + CW'(1);
                if (group_left_reg == '0) begin
                    // Code byte: open a group, emit the implicit zero if due
                    group_left_next = line_byte - 8'd1;
                    full_next       = (line_byte == FULL_CODE);
                    dec_take        = !full_reg;
                end
                else begin
                    group_left_next = group_left_reg - 8'd1;
                    dec_take        = 1'b1;
                    dec_val         = line_byte;
                end

                if (dec_take) begin
                    // Capture header bytes
                    if (dec_reg == CW'(0)) begin
                        type_next = dec_val;
                    end
                    else if (dec_reg == CW'(1)) begin
                        seq_next = dec_val;
                    end
                    else if (dec_reg == CW'(2)) begin
                        len_next = {len_reg[15:8], dec_val};
                    end
                    else if (dec_reg == CW'(3)) begin
                        len_next = {dec_val, len_reg[7:0]};
                    end

                    // Advance the two-byte delay line into the CRC
                    if (fill_reg == 2'd2) begin
                        crc_next = crc16_byte(crc_reg, d0_reg);
                    end
                    else begin
                        fill_next = fill_reg + 2'd1;
                    end
                    d0_next  = d1_reg;
                    d1_next  = dec_val;
                    dec_next = dec_reg + CW'(1);

                    res_valid      = 1'b1;
                    res.kind       = KIND_BYTE;
                    res.data_byte  = dec_val;
                    res.byte_index = idx_low;
                end
            end

            if (restart) begin
                enc_next        = '0;
                dec_next        = '0;
                group_left_next = '0;
                full_next       = 1'b1;
                type_next       = '0;
                seq_next        = '0;
                len_next        = '0;
                crc_next        = CRC_INIT;
                d0_next         = '0;
                d1_next         = '0;
                fill_next       = '0;
            end
        end
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enc_reg        <= '0;
            dec_reg        <= '0;
            group_left_reg <= '0;
            full_reg       <= 1'b1;
            type_reg       <= '0;
            seq_reg        <= '0;
            len_reg        <= '0;
            crc_reg        <= CRC_INIT;
            d0_reg         <= '0;
            d1_reg         <= '0;
            fill_reg       <= '0;
        end
        else begin
            enc_reg        <= enc_next;
            dec_reg        <= dec_next;
            group_left_reg <= group_left_next;
            full_reg       <= full_next;
            type_reg       <= type_next;
            seq_reg        <= seq_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            d0_reg         <= d0_next;
            d1_reg         <= d1_next;
            fill_reg       <= fill_next;
        end
    end

    `CDC_ASSERT_IMPL(a_enc_bound, clk, rst_n, 1'b1, enc_reg <= CW'(MAX_ENCODED))
    `CDC_ASSERT_IMPL(a_dec_le_enc, clk, rst_n, 1'b1, dec_reg <= enc_reg)
    `CDC_ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg != 2'd3)
    `CDC_ASSERT_NEXT(a_delim_restart, clk, rst_n,
                     take && line_byte == DELIM_BYTE,
                     enc_reg == '0 && dec_reg == '0 && crc_reg == CRC_INIT)
    `CDC_ASSERT_IMPL(a_verdict_no_data, clk, rst_n,
                     res_valid && res.kind != KIND_BYTE,
                     res.data_byte == '0 && res.byte_index == '0)

endmodule

>>> src/cdc_out_stage.sv
module cdc_out_stage
    import cdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        res_valid,
    input  cdc_result_t res,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output cdc_result_t out_res
);

    logic        valid_reg, valid_next;
    cdc_result_t res_reg;
    logic        load;

    // Accept whenever the held result is empty or leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign load      = take && res_valid;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

>>> src/cobs_deframer_crc16_check_unit.sv
// Output: a result is registered and presented on the master side in the cycle after the transfer
// that causes it.
// Throughput: one line byte per cycle while the sink keeps up; the output register
// passes a result while the next byte is taken; the CRC trails by two bytes.
// Reset: rst_n clears the frame state (CRC to 0xFFFF) and empties the output register.
module cobs_deframer_crc16_check_unit
    import cdc_pkg::*;
#(
    parameter int MAX_ENCODED = MAX_ENCODED_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] line_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [7:0] data_byte, [16:8] byte_index,
                                       // [24:17] frame_type, [32:25] frame_seq,
                                       // [48:33] body_length, [55:49] zero
    output logic [2:0]  m_axis_tuser   // [2:0] kind
);

    logic        take;
    logic        res_valid;
    cdc_result_t res;
    cdc_result_t out_res;

    assign take = s_axis_tvalid && s_axis_tready;

    // Decode and check
    cdc_frame_core #(
        .MAX_ENCODED (MAX_ENCODED)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .line_byte (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Register results toward the master side
    cdc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack fields from the lowest bit up
    assign m_axis_tdata = {7'd0, out_res.body_length, out_res.frame_seq, out_res.frame_type,
                           out_res.byte_index, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

>>> tb/sv/cobs_deframer_crc16_check_unit_test.sv
module cobs_deframer_crc16_check_unit_test;
    import cdc_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int QUIET_TAIL   = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [7:0] octet_q_t [$];

    typedef struct packed {
        logic [7:0]  line;
        logic        typed;
        logic        yields;
        cdc_result_t result;
    } dir_row_t;

    localparam cdc_result_t NO_RESULT = '0;
    localparam cdc_result_t DROP_RESULT = '{KIND_DROPPED, 8'h00, 9'd0, 8'h00, 8'h00, 16'h0000};

    // Directed rows: typed results where they follow directly from the coding rules
    localparam dir_row_t DIR_ROWS [24] = '{
        // empty frame straight after reset
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        // group opened for four bytes but closed after one
        '{8'h05, 1'b1, 1'b0, NO_RESULT},
        '{8'h11, 1'b1, 1'b1, '{KIND_BYTE, 8'h11, 9'd0, 8'h00, 8'h00, 16'h0000}},
        '{8'h00, 1'b1, 1'b1, DROP_RESULT},
        // frame too short to hold a header and a CRC
        '{8'h03, 1'b1, 1'b0, NO_RESULT},
        '{8'hAA, 1'b1, 1'b1, '{KIND_BYTE, 8'hAA, 9'd0, 8'h00, 8'h00, 16'h0000}},
        '{8'hBB, 1'b1, 1'b1, '{KIND_BYTE, 8'hBB, 9'd1, 8'h00, 8'h00, 16'h0000}},
        '{8'h00, 1'b1, 1'b1, DROP_RESULT},
        // all-ones length field: body length cannot match
        '{8'h07, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{KIND_BYTE, 8'hFF, 9'd0, 8'h00, 8'h00, 16'h0000}},
        '{8'h01, 1'b1, 1'b1, '{KIND_BYTE, 8'h01, 9'd1, 8'h00, 8'h00, 16'h0000}},
        '{8'hFF, 1'b1, 1'b1, '{KIND_BYTE, 8'hFF, 9'd2, 8'h00, 8'h00, 16'h0000}},
        '{8'hFF, 1'b1, 1'b1, '{KIND_BYTE, 8'hFF, 9'd3, 8'h00, 8'h00, 16'h0000}},
        '{8'h12, 1'b1, 1'b1, '{KIND_BYTE, 8'h12, 9'd4, 8'h00, 8'h00, 16'h0000}},
        '{8'h34, 1'b1, 1'b1, '{KIND_BYTE, 8'h34, 9'd5, 8'h00, 8'h00, 16'h0000}},
        '{8'h00, 1'b1, 1'b1, '{KIND_LEN_BAD, 8'h00, 9'd0, 8'hFF, 8'h00, 16'hFFFF}},
        // implicit zeros from short groups, CRC checked by the predictor
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h03, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Deframer predictor state
    int          enc_count;
    int          dec_count;
    logic [7:0]  grp_left;
    logic        grp_full;
    logic        coding_bad;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_seq;
    logic [15:0] hdr_len;
    logic [15:0] crc_acc;
    logic [7:0]  tail_bytes [2];
    int          tail_fill;

    cdc_result_t want_q [$];
    int          items_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    bit          quiet = 1'b0;
    bit          hold_done = 1'b0;

    cobs_deframer_crc16_check_unit #(
        .MAX_ENCODED(MAX_ENCODED_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-16/CCITT-FALSE, one input bit at a time
    function automatic logic [15:0] crc_ccitt(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void frame_clear();
        enc_count = 0;
        dec_count = 0;
        grp_left = 8'h00;
        grp_full = 1'b1;
        coding_bad = 1'b0;
        hdr_type = 8'h00;
        hdr_seq = 8'h00;
        hdr_len = 16'h0000;
        crc_acc = CRC_INIT;
        tail_bytes[0] = 8'h00;
        tail_bytes[1] = 8'h00;
        tail_fill = 0;
    endfunction

    // Capture header bytes, push the byte through the two-byte CRC delay
    function automatic cdc_result_t take_byte(input logic [7:0] b);
        cdc_result_t r;
        case (dec_count)
            0: hdr_type = b;
            1: hdr_seq = b;
            2: hdr_len[7:0] = b;
            3: hdr_len[15:8] = b;
            default: ;
        endcase
        if (tail_fill >= 2)
            crc_acc = crc_ccitt(crc_acc, tail_bytes[0]);
        else
            tail_fill++;
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = b;
        r = '0;
        r.kind = KIND_BYTE;
        r.data_byte = b;
        r.byte_index = dec_count[8:0];
        dec_count++;
        return r;
    endfunction

    // Advance the predictor by one line byte; returns 1 when a result follows
    function automatic bit deframe_predict(input logic [7:0] b, output cdc_result_t r);
        bit emit_zero;
        r = '0;
        if (b == DELIM_BYTE)
        begin
            if (enc_count == 0)
            begin
                frame_clear();
                return 1'b0;
            end
            if (grp_left != 0)
                coding_bad = 1'b1;
            if (coding_bad || dec_count < MIN_DECODED)
            begin
                r.kind = KIND_DROPPED;
            end
            else if (int'(hdr_len) + MIN_DECODED != dec_count)
            begin
                r.kind = KIND_LEN_BAD;
                r.frame_type = hdr_type;
                r.body_length = hdr_len;
            end
            else
            begin
                r.kind = ({tail_bytes[1], tail_bytes[0]} == crc_acc) ? KIND_OK : KIND_CRC_BAD;
                r.frame_type = hdr_type;
                r.frame_seq = hdr_seq;
                r.body_length = hdr_len;
            end
            frame_clear();
            return 1'b1;
        end
        // buffer full: drop and start over
        if (enc_count >= MAX_ENCODED_DEF)
        begin
            r.kind = KIND_DROPPED;
            frame_clear();
            return 1'b1;
        end
        enc_count++;
        if (grp_left == 0)
        begin
            emit_zero = !grp_full;
            grp_left = b - 8'd1;
            grp_full = (b == FULL_CODE);
            if (emit_zero)
            begin
                r = take_byte(8'h00);
                return 1'b1;
            end
            return 1'b0;
        end
        grp_left--;
        r = take_byte(b);
        return 1'b1;
    endfunction

    function automatic void append_group(ref octet_q_t coded, ref octet_q_t run);
        coded.push_back(8'(run.size() + 1));
        foreach (run[j])
            coded.push_back(run[j]);
        run.delete();
    endfunction

    function automatic octet_q_t stuff_bytes(input octet_q_t plain);
        octet_q_t coded;
        octet_q_t run;
        foreach (plain[i])
        begin
            if (plain[i] == 8'h00)
            begin
                append_group(coded, run);
            end
            else
            begin
                run.push_back(plain[i]);
                if (run.size() == 254)
                    append_group(coded, run);
            end
        end
        append_group(coded, run);
        return coded;
    endfunction

    // Header, random body, CRC low byte first
    function automatic octet_q_t build_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                                             input int pay_len, input int zero_pct,
                                             input logic [15:0] len_field, input bit spoil_crc);
        octet_q_t    plain;
        logic [15:0] crc;
        plain.push_back(ftype);
        plain.push_back(fseq);
        plain.push_back(len_field[7:0]);
        plain.push_back(len_field[15:8]);
        repeat (pay_len)
        begin
            if ($urandom_range(0, 99) < zero_pct)
                plain.push_back(8'h00);
            else
                plain.push_back(8'($urandom_range(0, 255)));
        end
        crc = CRC_INIT;
        foreach (plain[i])
            crc = crc_ccitt(crc, plain[i]);
        if (spoil_crc)
            crc = crc ^ 16'(1 << $urandom_range(0, 15));
        plain.push_back(crc[7:0]);
        plain.push_back(crc[15:8]);
        return plain;
    endfunction

    // Offer one byte, hold it until the transfer, then predict
    task automatic send_octet(input logic [7:0] b, output bit got, output cdc_result_t r);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = deframe_predict(b, r);
        items_taken++;
        if (items_taken >= ITEM_TARGET - QUIET_TAIL)
            quiet = 1'b1;
    endtask

    task automatic send_coded(input octet_q_t coded);
        bit          got;
        cdc_result_t r;
        coded.push_back(DELIM_BYTE);
        foreach (coded[i])
        begin
            send_octet(coded[i], got, r);
            if (got)
                want_q.push_back(r);
        end
    endtask

    // Mostly well-formed frames, the rest broken or noise
    task automatic send_random_frame();
        int          pick;
        int          sz;
        int          pay_len;
        int          zero_pct;
        int          cut;
        logic [15:0] len_field;
        octet_q_t    plain;
        octet_q_t    coded;
        pick = $urandom_range(0, 99);
        sz = $urandom_range(0, 19);
        if (sz < 15)
            pay_len = $urandom_range(0, 24);
        else if (sz < 19)
            pay_len = $urandom_range(25, 200);
        else
            pay_len = $urandom_range(201, 480);
        case ($urandom_range(0, 3))
            0: zero_pct = 0;
            1: zero_pct = 5;
            2: zero_pct = 30;
            default: zero_pct = 80;
        endcase
        len_field = 16'(pay_len);
        if (pick < 68)
        begin
            plain = build_frame(8'($urandom), 8'($urandom), pay_len, zero_pct, len_field, 1'b0);
            coded = stuff_bytes(plain);
        end
        else if (pick < 76)
        begin
            plain = build_frame(8'($urandom), 8'($urandom), pay_len, zero_pct, len_field, 1'b1);
            coded = stuff_bytes(plain);
        end
        else if (pick < 82)
        begin
            len_field = len_field ^ 16'($urandom_range(1, 65535));
            plain = build_frame(8'($urandom), 8'($urandom), pay_len, zero_pct, len_field, 1'b0);
            coded = stuff_bytes(plain);
        end
        else if (pick < 88)
        begin
            // cut a good frame short
            plain = build_frame(8'($urandom), 8'($urandom), pay_len, zero_pct, len_field, 1'b0);
            coded = stuff_bytes(plain);
            cut = $urandom_range(1, coded.size() - 1);
            while (coded.size() > cut)
                void'(coded.pop_back());
        end
        else if (pick < 93)
        begin
            repeat ($urandom_range(0, 5))
                plain.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom));
            coded = stuff_bytes(plain);
        end
        else if (pick < 96)
        begin
            repeat ($urandom_range(1, 24))
                coded.push_back(8'($urandom));
        end
        else if (pick < 98)
        begin
            // empty frame: delimiter only
        end
        else
        begin
            repeat (MAX_ENCODED_DEF + $urandom_range(1, 30))
                coded.push_back(8'($urandom_range(1, 255)));
        end
        send_coded(coded);
    endtask

    // Sink: random stalls, one long hold-off to back the block up
    initial
    begin : sink
        wait (rst_n);
        forever
        begin
            if (!hold_done && items_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        cdc_result_t got;
        cdc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8], m_axis_tdata[24:17],
                    m_axis_tdata[32:25], m_axis_tdata[48:33]};
            results_seen++;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d data %02h index %0d",
                             got.kind, got.data_byte, got.byte_index);
            end
            else
            begin
                want = want_q.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.byte_index !== want.byte_index || got.frame_type !== want.frame_type ||
                    got.frame_seq !== want.frame_seq || got.body_length !== want.body_length)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result %0d mismatch (exp/act): kind %0d/%0d data %02h/%02h",
                                  " index %0d/%0d type %02h/%02h seq %02h/%02h length %04h/%04h"},
                                 results_seen, want.kind, got.kind, want.data_byte,
                                 got.data_byte, want.byte_index, got.byte_index,
                                 want.frame_type, got.frame_type, want.frame_seq,
                                 got.frame_seq, want.body_length, got.body_length);
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        bit          got;
        cdc_result_t r;
        octet_q_t    coded;
        frame_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (DIR_ROWS[i])
        begin
            send_octet(DIR_ROWS[i].line, got, r);
            if (DIR_ROWS[i].typed)
            begin
                if (DIR_ROWS[i].yields)
                    want_q.push_back(DIR_ROWS[i].result);
            end
            else if (got)
            begin
                want_q.push_back(r);
            end
        end
        send_coded(stuff_bytes(build_frame(8'h7E, 8'h01, 3, 50, 16'd3, 1'b0)));

        // Long frame with full groups, then an overflow made of implicit zeros
        send_coded(stuff_bytes(build_frame(8'h00, 8'hFF, 300, 0, 16'd300, 1'b0)));
        repeat (MAX_ENCODED_DEF + 8)
            coded.push_back(8'h01);
        send_coded(coded);

        while (items_taken < ITEM_TARGET)
            send_random_frame();
        s_axis_tvalid <= 1'b0;

        // Drain
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/cdc_pkg.sv
src/cdc_frame_core.sv
src/cdc_out_stage.sv
src/cobs_deframer_crc16_check_unit.sv
tb/sv/cobs_deframer_crc16_check_unit_test.sv
